FILE: rtl/core/swra_pkg.sv
package swra_pkg;

   // fixed field widths
   localparam int TIME_W     = 32;
   localparam int TOTAL_W    = 32;
   localparam int SPAN_OUT_W = 7;
   localparam int RATE_W     = 40;
   localparam int COUNT_W    = 16;
   localparam int THRESH_W   = 16;
   localparam int FRAC_BITS  = 8;
   localparam int EVENT_W    = 2;

   // parameter defaults
   localparam int WINDOW_SECONDS_DEF = 120;
   localparam int RING_SLOTS_DEF     = 128;

   localparam logic [THRESH_W-1:0] THRESH_RESET = 16'd10;
   localparam logic [COUNT_W-1:0]  COUNT_MAX    = 16'hFFFF;
   localparam logic [TOTAL_W-1:0]  TOTAL_MAX    = 32'hFFFF_FFFF;

   // alarm event codes
   localparam logic [EVENT_W-1:0] EVT_NONE      = 2'd0;
   localparam logic [EVENT_W-1:0] EVT_RAISED    = 2'd1;
   localparam logic [EVENT_W-1:0] EVT_RECOVERED = 2'd2;

   typedef struct packed {
      logic clr_step;
      logic latch_req;
      logic cap_slot;
      logic take_first;
      logic set_oldest_t;
      logic set_newest_t;
      logic walk_init;
      logic walk_rd;
      logic walk_evict;
      logic walk_skip;
      logic walk_found;
      logic cnt_rd;
      logic cnt_wr;
      logic mul;
      logic cmp_alarm;
      logic div_rate;
      logic load_out;
   } cmd_type;

   typedef struct packed {
      logic clr_last;
      logic div_done;
      logic empty;
      logic t_lt_oldest;
      logic stale;
      logic t_le_newest;
      logic need_evict;
      logic walk_past;
      logic walk_below_lo;
      logic rd_nonzero;
   } status_type;

endpackage

FILE: rtl/core/sliding_window_rate_alarm_core.sv
// channel   direction  handshake              word
// req       in         req_valid / req_ready  request_time, one request stamp in seconds
// rsp       out        rsp_valid / rsp_ready  window total, span, rate q8, alarm, event, stamp
// csr       in         csr_valid / csr_ready  rate_threshold, always ready
//
// each item runs the 40-step serial division for the rate, and a stale stamp skips
// the count update; eviction walks the ring slot by slot, at most window slots,
// and the walk also ends when it steps past the newest second
// after reset a clearing pass zeroes the ring, one slot per cycle, req_ready low
// a finished word waits in the output register while the next request is taken;
// that request then holds before loading its result until the word is taken
module sliding_window_rate_alarm_core #(
   parameter int WINDOW_SECONDS = swra_pkg::WINDOW_SECONDS_DEF,
   parameter int RING_SLOTS     = swra_pkg::RING_SLOTS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   // request channel
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [swra_pkg::TIME_W-1:0]      req_request_time,
   // result channel
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [swra_pkg::TOTAL_W-1:0]     rsp_window_total,
   output logic [swra_pkg::SPAN_OUT_W-1:0]  rsp_window_span,
   output logic [swra_pkg::RATE_W-1:0]      rsp_rate_q8,
   output logic                             rsp_alarm_active,
   output logic [swra_pkg::EVENT_W-1:0]     rsp_alarm_event,
   output logic [swra_pkg::TIME_W-1:0]      rsp_event_time,
   // threshold register write
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [swra_pkg::THRESH_W-1:0]    csr_rate_threshold
);
   import swra_pkg::*;

   cmd_type    cmd;
   status_type status;

   // threshold writes go straight into a register, so the port never stalls
   assign csr_ready = 1'b1;

   // sequencer: clear pass, classify stamp, walk evicted seconds, count, alarm, rate
   swra_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // count ring, window bounds, running total, alarm state, divider, output word
   swra_dpath #(
      .WINDOW_SECONDS (WINDOW_SECONDS),
      .RING_SLOTS     (RING_SLOTS)
   ) u_dpath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .status             (status),
      .req_request_time   (req_request_time),
      .csr_we             (csr_valid & csr_ready),
      .csr_rate_threshold (csr_rate_threshold),
      .rsp_window_total   (rsp_window_total),
      .rsp_window_span    (rsp_window_span),
      .rsp_rate_q8        (rsp_rate_q8),
      .rsp_alarm_active   (rsp_alarm_active),
      .rsp_alarm_event    (rsp_alarm_event),
      .rsp_event_time     (rsp_event_time)
   );

endmodule

FILE: rtl/core/swra_div.sv
module swra_div #(
   parameter int NUM_W = 40,
   parameter int DEN_W = 11
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [NUM_W-1:0] num,
   input  logic [DEN_W-1:0] den,
   output logic             done,
   output logic [NUM_W-1:0] quot
);
   localparam int CNT_W = $clog2(NUM_W + 1);

   logic             busy_ff;
   logic             done_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic [NUM_W-1:0] quot_ff;
   logic [DEN_W-1:0] rem_ff;
   logic [DEN_W-1:0] den_ff;

   logic [DEN_W:0]   trial;
   logic             fits;
   logic [DEN_W:0]   diff;

   // one quotient bit per cycle, restoring
   always_comb begin
      trial = {rem_ff, quot_ff[NUM_W-1]};
      fits  = trial >= {1'b0, den_ff};
      diff  = trial - {1'b0, den_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= CNT_W'(NUM_W);
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - CNT_W'(1);
            if (cnt_ff == CNT_W'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         quot_ff <= num;
         rem_ff  <= '0;
         den_ff  <= den;
      end else if (busy_ff) begin
         quot_ff <= {quot_ff[NUM_W-2:0], fits};
         rem_ff  <= fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      end
   end

   assign done = done_ff;
   assign quot = quot_ff;

endmodule

FILE: rtl/core/swra_dpath.sv
module swra_dpath #(
   parameter int WINDOW_SECONDS = swra_pkg::WINDOW_SECONDS_DEF,
   parameter int RING_SLOTS     = swra_pkg::RING_SLOTS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  swra_pkg::cmd_type                 cmd,
   output swra_pkg::status_type              status,
   input  logic [swra_pkg::TIME_W-1:0]       req_request_time,
   input  logic                              csr_we,
   input  logic [swra_pkg::THRESH_W-1:0]     csr_rate_threshold,
   output logic [swra_pkg::TOTAL_W-1:0]      rsp_window_total,
   output logic [swra_pkg::SPAN_OUT_W-1:0]   rsp_window_span,
   output logic [swra_pkg::RATE_W-1:0]       rsp_rate_q8,
   output logic                              rsp_alarm_active,
   output logic [swra_pkg::EVENT_W-1:0]      rsp_alarm_event,
   output logic [swra_pkg::TIME_W-1:0]       rsp_event_time
);
   import swra_pkg::*;

   localparam int EFF_WINDOW = (WINDOW_SECONDS < RING_SLOTS) ? WINDOW_SECONDS : RING_SLOTS;
   localparam int SLOT_W     = $clog2(RING_SLOTS);
   // ring is a power of two deep, so the slot is the low stamp bits
   localparam int RING_DEPTH = 2 ** SLOT_W;
   localparam int SPAN_W     = $clog2(EFF_WINDOW + 1);
   localparam int PROD_W     = THRESH_W + SPAN_W;
   localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(RING_DEPTH - 1);

   // per-second count ring
   logic [COUNT_W-1:0] ring_ff [RING_DEPTH];
   logic [COUNT_W-1:0] rd_data_ff;

   logic [TIME_W-1:0]   time_ff;
   logic [SLOT_W-1:0]   slot_t_ff;
   logic [TIME_W-1:0]   newest_ff;
   logic [TIME_W-1:0]   oldest_ff;
   logic [SLOT_W-1:0]   oldest_slot_ff;
   logic                empty_ff;
   logic                alarm_ff;
   logic [EVENT_W-1:0]  event_ff;
   logic [TOTAL_W-1:0]  total_ff;
   logic [THRESH_W-1:0] thresh_ff;
   logic [TIME_W-1:0]   lo_ff;
   logic [TIME_W:0]     walk_sec_ff;
   logic [SLOT_W-1:0]   walk_slot_ff;
   logic [SLOT_W-1:0]   clr_addr_ff;
   logic [SPAN_W-1:0]   span_ff;
   logic [PROD_W-1:0]   prod_ff;

   logic [TOTAL_W-1:0]    out_total_ff;
   logic [SPAN_OUT_W-1:0] out_span_ff;
   logic [RATE_W-1:0]     out_rate_ff;
   logic                  out_alarm_ff;
   logic [EVENT_W-1:0]    out_event_ff;
   logic [TIME_W-1:0]     out_time_ff;

   logic                rd_en;
   logic [SLOT_W-1:0]   rd_addr;
   logic                wr_en;
   logic [SLOT_W-1:0]   wr_addr;
   logic [COUNT_W-1:0]  wr_data;
   logic                cnt_sat;
   logic [SLOT_W-1:0]   walk_slot_nxt;
   logic [SPAN_W-1:0]   span_in;
   logic                high;

   logic                div_start;
   logic [RATE_W-1:0]   div_num;
   logic [SPAN_W-1:0]   div_den;
   logic                div_done;
   logic [RATE_W-1:0]   div_quot;

   swra_div #(
      .NUM_W (RATE_W),
      .DEN_W (SPAN_W)
   ) u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (div_den),
      .done  (div_done),
      .quot  (div_quot)
   );

   // rate division, started once the span is known
   assign div_start = cmd.div_rate;
   assign div_num   = {total_ff, FRAC_BITS'(0)};
   assign div_den   = span_ff;

   always_comb begin
      rd_en   = cmd.walk_rd | cmd.cnt_rd;
      rd_addr = cmd.walk_rd ? walk_slot_ff : slot_t_ff;
      cnt_sat = rd_data_ff == COUNT_MAX;
      wr_en   = cmd.clr_step | cmd.walk_evict | (cmd.cnt_wr & ~cnt_sat);
      if (cmd.clr_step) begin
         wr_addr = clr_addr_ff;
      end else if (cmd.walk_evict) begin
         wr_addr = walk_slot_ff;
      end else begin
         wr_addr = slot_t_ff;
      end
      wr_data       = cmd.cnt_wr ? rd_data_ff + COUNT_W'(1) : '0;
      walk_slot_nxt = (walk_slot_ff == LAST_SLOT) ? '0 : walk_slot_ff + SLOT_W'(1);
      span_in       = SPAN_W'(newest_ff - oldest_ff + TIME_W'(1));
      high          = total_ff >= TOTAL_W'(prod_ff);
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         ring_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= ring_ff[rd_addr];
      end
   end

   always_comb begin
      status.clr_last      = clr_addr_ff == LAST_SLOT;
      status.div_done      = div_done;
      status.empty         = empty_ff;
      status.t_lt_oldest   = time_ff < oldest_ff;
      status.t_le_newest   = time_ff <= newest_ff;
      status.stale         = ({1'b0, newest_ff} - {1'b0, time_ff}) >= (TIME_W + 1)'(EFF_WINDOW);
      status.need_evict    = ({1'b0, time_ff} - {1'b0, oldest_ff}) >= (TIME_W + 1)'(EFF_WINDOW);
      status.walk_past     = walk_sec_ff > {1'b0, newest_ff};
      status.walk_below_lo = walk_sec_ff < {1'b0, lo_ff};
      status.rd_nonzero    = rd_data_ff != '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_addr_ff <= '0;
         newest_ff   <= '0;
         oldest_ff   <= '0;
         empty_ff    <= 1'b1;
         alarm_ff    <= 1'b0;
         total_ff    <= '0;
         thresh_ff   <= THRESH_RESET;
      end else begin
         if (csr_we) begin
            thresh_ff <= csr_rate_threshold;
         end
         if (cmd.clr_step) begin
            clr_addr_ff <= clr_addr_ff + SLOT_W'(1);
         end
         if (cmd.take_first) begin
            oldest_ff <= time_ff;
            newest_ff <= time_ff;
            empty_ff  <= 1'b0;
         end
         if (cmd.set_oldest_t) begin
            oldest_ff <= time_ff;
         end
         if (cmd.set_newest_t) begin
            newest_ff <= time_ff;
         end
         if (cmd.walk_found) begin
            oldest_ff <= walk_sec_ff[TIME_W-1:0];
         end
         if (cmd.walk_evict) begin
            total_ff <= total_ff - TOTAL_W'(rd_data_ff);
         end else if (cmd.cnt_wr && !cnt_sat && total_ff != TOTAL_MAX) begin
            total_ff <= total_ff + TOTAL_W'(1);
         end
         if (cmd.cmp_alarm) begin
            alarm_ff <= high;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.latch_req) begin
         time_ff <= req_request_time;
      end
      if (cmd.cap_slot) begin
         slot_t_ff <= time_ff[SLOT_W-1:0];
      end
      if (cmd.take_first || cmd.set_oldest_t) begin
         oldest_slot_ff <= slot_t_ff;
      end else if (cmd.walk_found) begin
         oldest_slot_ff <= walk_slot_ff;
      end
      if (cmd.walk_init) begin
         lo_ff        <= time_ff - TIME_W'(EFF_WINDOW - 1);
         walk_sec_ff  <= {1'b0, oldest_ff};
         walk_slot_ff <= oldest_slot_ff;
      end else if (cmd.walk_evict || cmd.walk_skip) begin
         walk_sec_ff  <= walk_sec_ff + (TIME_W + 1)'(1);
         walk_slot_ff <= walk_slot_nxt;
      end
      if (cmd.mul) begin
         span_ff <= span_in;
         prod_ff <= PROD_W'(thresh_ff) * PROD_W'(span_in);
      end
      if (cmd.cmp_alarm) begin
         if (!alarm_ff && high) begin
            event_ff <= EVT_RAISED;
         end else if (alarm_ff && !high) begin
            event_ff <= EVT_RECOVERED;
         end else begin
            event_ff <= EVT_NONE;
         end
      end
      if (cmd.load_out) begin
         out_total_ff <= total_ff;
         out_span_ff  <= SPAN_OUT_W'(span_ff);
         out_rate_ff  <= div_quot;
         out_alarm_ff <= alarm_ff;
         out_event_ff <= event_ff;
         out_time_ff  <= newest_ff;
      end
   end

   assign rsp_window_total = out_total_ff;
   assign rsp_window_span  = out_span_ff;
   assign rsp_rate_q8      = out_rate_ff;
   assign rsp_alarm_active = out_alarm_ff;
   assign rsp_alarm_event  = out_event_ff;
   assign rsp_event_time   = out_time_ff;

endmodule

FILE: rtl/core/swra_ctrl.sv
module swra_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  swra_pkg::status_type status,
   output swra_pkg::cmd_type    cmd
);
   import swra_pkg::*;

   localparam logic [3:0] S_CLEAR    = 4'd0;
   localparam logic [3:0] S_IDLE     = 4'd1;
   localparam logic [3:0] S_MOD      = 4'd2;
   localparam logic [3:0] S_CLASS    = 4'd3;
   localparam logic [3:0] S_WALK_RD  = 4'd4;
   localparam logic [3:0] S_WALK_CHK = 4'd5;
   localparam logic [3:0] S_CNT_RD   = 4'd6;
   localparam logic [3:0] S_CNT_WR   = 4'd7;
   localparam logic [3:0] S_MUL      = 4'd8;
   localparam logic [3:0] S_CMP      = 4'd9;
   localparam logic [3:0] S_DIV      = 4'd10;
   localparam logic [3:0] S_OUT      = 4'd11;

   logic [3:0] state_ff;
   logic [3:0] state_in;
   logic       rsp_valid_ff;
   logic       rsp_valid_in;
   logic       out_free;

   assign req_ready = state_ff == S_IDLE;
   assign rsp_valid = rsp_valid_ff;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      case (state_ff)
         S_CLEAR: begin
            cmd.clr_step = 1'b1;
            if (status.clr_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               cmd.latch_req = 1'b1;
               state_in      = S_MOD;
            end
         end
         S_MOD: begin
            cmd.cap_slot = 1'b1;
            state_in     = S_CLASS;
         end
         S_CLASS: begin
            if (status.empty) begin
               cmd.take_first = 1'b1;
               state_in       = S_CNT_RD;
            end else if (status.t_lt_oldest) begin
               if (status.stale) begin
                  state_in = S_MUL;
               end else begin
                  cmd.set_oldest_t = 1'b1;
                  state_in         = S_CNT_RD;
               end
            end else if (status.t_le_newest) begin
               state_in = S_CNT_RD;
            end else if (status.need_evict) begin
               cmd.walk_init = 1'b1;
               state_in      = S_WALK_RD;
            end else begin
               cmd.set_newest_t = 1'b1;
               state_in         = S_CNT_RD;
            end
         end
         S_WALK_RD: begin
            if (status.walk_past) begin
               cmd.set_oldest_t = 1'b1;
               cmd.set_newest_t = 1'b1;
               state_in         = S_CNT_RD;
            end else begin
               cmd.walk_rd = 1'b1;
               state_in    = S_WALK_CHK;
            end
         end
         S_WALK_CHK: begin
            if (status.walk_below_lo) begin
               cmd.walk_evict = 1'b1;
               state_in       = S_WALK_RD;
            end else if (status.rd_nonzero) begin
               cmd.walk_found   = 1'b1;
               cmd.set_newest_t = 1'b1;
               state_in         = S_CNT_RD;
            end else begin
               cmd.walk_skip = 1'b1;
               state_in      = S_WALK_RD;
            end
         end
         S_CNT_RD: begin
            cmd.cnt_rd = 1'b1;
            state_in   = S_CNT_WR;
         end
         S_CNT_WR: begin
            cmd.cnt_wr = 1'b1;
            state_in   = S_MUL;
         end
         S_MUL: begin
            cmd.mul  = 1'b1;
            state_in = S_CMP;
         end
         S_CMP: begin
            cmd.cmp_alarm = 1'b1;
            cmd.div_rate  = 1'b1;
            state_in      = S_DIV;
         end
         S_DIV: begin
            if (status.div_done) begin
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            if (out_free) begin
               cmd.load_out = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load_out) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

FILE: rtl/core/swra_checker.sv
module swra_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_valid,
   input logic                             req_ready,
   input logic                             rsp_valid,
   input logic                             rsp_ready,
   input logic [swra_pkg::TOTAL_W-1:0]     rsp_window_total,
   input logic                             rsp_alarm_active,
   input logic [swra_pkg::EVENT_W-1:0]     rsp_alarm_event
);
   import swra_pkg::*;

   // reset starts the clearing pass with no word out
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_ready)
      else $error("busy or valid right after reset");

   // one request at a time
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while another is in work");

   // event code agrees with alarm state
   a_event_state: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_alarm_event == EVT_NONE)
                 || (rsp_alarm_event == EVT_RAISED && rsp_alarm_active)
                 || (rsp_alarm_event == EVT_RECOVERED && !rsp_alarm_active))
      else $error("alarm event does not match alarm state");

   // stalled word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_window_total)
                                && $stable(rsp_alarm_event))
      else $error("result word changed while stalled");

endmodule

bind sliding_window_rate_alarm_core swra_checker u_swra_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_valid),
   .req_ready        (req_ready),
   .rsp_valid        (rsp_valid),
   .rsp_ready        (rsp_ready),
   .rsp_window_total (rsp_window_total),
   .rsp_alarm_active (rsp_alarm_active),
   .rsp_alarm_event  (rsp_alarm_event)
);

FILE: tb/testbench.sv
`timescale 1ns / 100ps

module testbench;
   import swra_pkg::*;

   // predictor sizing follows the block's default parameters
   localparam int          RING         = RING_SLOTS_DEF;
   localparam logic [63:0] WINDOW_LEN   = (WINDOW_SECONDS_DEF < RING_SLOTS_DEF) ?
                                          WINDOW_SECONDS_DEF : RING_SLOTS_DEF;
   localparam logic [TIME_W-1:0] STAMP_MAX = '1;
   localparam int unsigned CYCLE_LIMIT  = 1_000_000;
   localparam int          RANDOM_PHASES   = 6;
   localparam int          WORDS_PER_PHASE = 64;
   // worst item grows with each walked slot
   localparam int          TAIL_CYCLES  = 400;
   localparam int          REPORT_LIMIT = 10;

   // one result word as the block reports it
   typedef struct packed {
      logic [TOTAL_W-1:0]    total;
      logic [SPAN_OUT_W-1:0] span;
      logic [RATE_W-1:0]     rate;
      logic                  active;
      logic [EVENT_W-1:0]    alarm_evt;
      logic [TIME_W-1:0]     stamp;
   } window_report_type;

   typedef enum logic {ROW_REQ, ROW_CSR} row_kind_type;

   // one line of the directed table; known rows carry a hand-written result
   typedef struct packed {
      row_kind_type       kind;
      logic [TIME_W-1:0]  value;
      logic               known;
      window_report_type  want;
   } plan_row_type;

   logic                    clock = 1'b0;
   logic                    reset;
   logic                    req_valid;
   logic                    req_ready;
   logic [TIME_W-1:0]       req_request_time;
   logic                    rsp_valid;
   logic                    rsp_ready = 1'b0;
   logic [TOTAL_W-1:0]      rsp_window_total;
   logic [SPAN_OUT_W-1:0]   rsp_window_span;
   logic [RATE_W-1:0]       rsp_rate_q8;
   logic                    rsp_alarm_active;
   logic [EVENT_W-1:0]      rsp_alarm_event;
   logic [TIME_W-1:0]       rsp_event_time;
   logic                    csr_valid;
   logic                    csr_ready;
   logic [THRESH_W-1:0]     csr_rate_threshold;

   // idle percentages, changed per phase
   int                      send_idle_pct = 0;
   int                      stall_pct = 0;
   int                      error_count = 0;
   int unsigned             cycle_count = 0;

   window_report_type       expected_reports [$];

   // predictor copy of the window state
   logic [COUNT_W-1:0]      ring_counts [RING];
   logic [TOTAL_W-1:0]      window_sum;
   logic [TIME_W-1:0]       newest_sec;
   logic [TIME_W-1:0]       oldest_sec;
   logic                    ring_empty;
   logic                    alarm_on;
   logic [THRESH_W-1:0]     threshold;

   sliding_window_rate_alarm_core dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_request_time   (req_request_time),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_window_total   (rsp_window_total),
      .rsp_window_span    (rsp_window_span),
      .rsp_rate_q8        (rsp_rate_q8),
      .rsp_alarm_active   (rsp_alarm_active),
      .rsp_alarm_event    (rsp_alarm_event),
      .rsp_event_time     (rsp_event_time),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_rate_threshold (csr_rate_threshold)
   );

   // 10 ns clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // one request lands in its per-second slot; a full slot drops it entirely
   function automatic void tally_second(input logic [63:0] sec);
      int unsigned idx = int'(sec % RING);
      if (ring_counts[idx] != COUNT_MAX) begin
         ring_counts[idx]++;
         if (window_sum != TOTAL_MAX)
            window_sum++;
      end
   endfunction

   // expected result word for one accepted stamp, advancing the window state
   function automatic window_report_type predict_window(input logic [TIME_W-1:0] stamp);
      window_report_type r;
      logic [63:0]    t;
      logic [63:0]    lo;
      logic [63:0]    s;
      logic [63:0]    found;
      logic [63:0]    span;
      logic [63:0]    rate;
      logic           high;
      t = 64'(stamp);
      if (ring_empty) begin
         // first stamp opens the window
         oldest_sec = stamp;
         newest_sec = stamp;
         ring_empty = 1'b0;
         tally_second(t);
      end else if (t < 64'(oldest_sec)) begin
         // older than the window start: extend back, or drop it if stale
         if (64'(newest_sec) - t < WINDOW_LEN) begin
            oldest_sec = stamp;
            tally_second(t);
         end
      end else if (t <= 64'(newest_sec)) begin
         tally_second(t);
      end else begin
         // new newest second; evict whatever falls out of the window
         if (t - 64'(oldest_sec) >= WINDOW_LEN) begin
            lo = t - WINDOW_LEN + 1;
            found = t;
            for (s = 64'(oldest_sec); s <= 64'(newest_sec) && s < lo; s++) begin
               window_sum -= 32'(ring_counts[s % RING]);
               ring_counts[s % RING] = '0;
            end
            // oldest survivor, or the new stamp itself after a large jump
            for (s = lo; s <= 64'(newest_sec) && found == t; s++) begin
               if (ring_counts[s % RING] != '0)
                  found = s;
            end
            oldest_sec = found[TIME_W-1:0];
         end
         newest_sec = stamp;
         tally_second(t);
      end

      span = 64'(newest_sec) - 64'(oldest_sec) + 1;
      // alarm holds while the average is at or above the threshold
      high = 64'(window_sum) >= 64'(threshold) * span;
      rate = (64'(window_sum) << FRAC_BITS) / span;
      r.alarm_evt = EVT_NONE;
      if (!alarm_on && high) begin
         alarm_on = 1'b1;
         r.alarm_evt = EVT_RAISED;
      end else if (alarm_on && !high) begin
         alarm_on = 1'b0;
         r.alarm_evt = EVT_RECOVERED;
      end
      r.total = window_sum;
      r.span = span[SPAN_OUT_W-1:0];
      r.rate = rate[RATE_W-1:0];
      r.active = alarm_on;
      r.stamp = newest_sec;
      return r;
   endfunction

   // random stamp around the current newest second, mostly well-formed traffic
   function automatic logic [TIME_W-1:0] pick_stamp();
      logic [63:0] base = 64'(newest_sec);
      logic [63:0] pick;
      int unsigned mode = $urandom_range(0, 99);
      if (mode < 50)
         pick = base + $urandom_range(0, 3);             // steady traffic
      else if (mode < 72)
         pick = base - $urandom_range(0, 119);           // late, inside the window
      else if (mode < 82)
         pick = base - $urandom_range(120, 400);         // mostly stale
      else if (mode < 93)
         pick = base + $urandom_range(60, 260);          // partial or full eviction
      else if (mode < 97)
         pick = 64'($urandom);                           // anywhere
      else
         pick = base + $urandom_range(1000, 100000);     // large jump
      // clamp underflow and overflow to the stamp range
      if (pick[63])
         pick = '0;
      else if (pick > 64'(STAMP_MAX))
         pick = 64'(STAMP_MAX);
      return pick[TIME_W-1:0];
   endfunction

   function automatic plan_row_type req_row(input logic [TIME_W-1:0] stamp);
      plan_row_type p;
      p = '0;
      p.kind = ROW_REQ;
      p.value = stamp;
      return p;
   endfunction

   function automatic plan_row_type known_row(input logic [TIME_W-1:0] stamp,
                                              input logic [TOTAL_W-1:0] total,
                                              input logic [SPAN_OUT_W-1:0] span,
                                              input logic [RATE_W-1:0] rate,
                                              input logic active,
                                              input logic [EVENT_W-1:0] alarm_evt);
      plan_row_type p;
      p = req_row(stamp);
      p.known = 1'b1;
      p.want.total = total;
      p.want.span = span;
      p.want.rate = rate;
      p.want.active = active;
      p.want.alarm_evt = alarm_evt;
      p.want.stamp = stamp;
      return p;
   endfunction

   function automatic plan_row_type csr_row(input logic [THRESH_W-1:0] value);
      plan_row_type p;
      p = '0;
      p.kind = ROW_CSR;
      p.value = TIME_W'(value);
      return p;
   endfunction

   // present one stamp, hold it until taken, then maybe go idle
   // valid is left high when the next word follows at once
   task automatic send_stamp(input logic [TIME_W-1:0] stamp, input logic known,
                             input window_report_type want);
      window_report_type predicted;
      int                gap;
      req_valid <= 1'b1;
      req_request_time <= stamp;
      do @(posedge clock); while (!req_ready);
      predicted = predict_window(stamp);
      expected_reports.push_back(known ? want : predicted);
      gap = 0;
      while ($urandom_range(0, 99) < send_idle_pct)
         gap++;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // threshold changes only once every pending word has come back
   task automatic write_threshold(input logic [THRESH_W-1:0] value);
      while (expected_reports.size() != 0)
         @(posedge clock);
      csr_valid <= 1'b1;
      csr_rate_threshold <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      threshold = value;
   endtask

   // receiver back-pressure
   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(0, 99) >= stall_pct);
   end

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   // compare each taken word with the oldest expectation
   always @(posedge clock) begin : report_check
      window_report_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_reports.size() == 0) begin
            error_count++;
            if (error_count <= REPORT_LIMIT)
               $display("unexpected word: total=%0d span=%0d stamp=%0h",
                        rsp_window_total, rsp_window_span, rsp_event_time);
         end else begin
            want = expected_reports.pop_front();
            if (rsp_window_total !== want.total || rsp_window_span !== want.span ||
                rsp_rate_q8 !== want.rate || rsp_alarm_active !== want.active ||
                rsp_alarm_event !== want.alarm_evt || rsp_event_time !== want.stamp) begin
               error_count++;
               if (error_count <= REPORT_LIMIT) begin
                  $display("mismatch: want total=%0d span=%0d rate=%0d alarm=%0b evt=%0d stamp=%0h",
                           want.total, want.span, want.rate, want.active,
                           want.alarm_evt, want.stamp);
                  $display("          got  total=%0d span=%0d rate=%0d alarm=%0b evt=%0d stamp=%0h",
                           rsp_window_total, rsp_window_span, rsp_rate_q8,
                           rsp_alarm_active, rsp_alarm_event, rsp_event_time);
               end
            end
         end
      end
   end

   initial begin : stimulus
      plan_row_type        plan [$];
      logic [THRESH_W-1:0] next_threshold;
      int                  phase;
      int                  k;
      logic [TIME_W-1:0]   stamp;

      reset = 1'b1;
      req_valid = 1'b0;
      req_request_time = '0;
      csr_valid = 1'b0;
      csr_rate_threshold = '0;

      // predictor starts from the reset state
      foreach (ring_counts[i])
         ring_counts[i] = '0;
      window_sum = '0;
      newest_sec = '0;
      oldest_sec = '0;
      ring_empty = 1'b1;
      alarm_on = 1'b0;
      threshold = THRESH_RESET;

      // directed table, threshold at its reset value to begin with
      plan.push_back(known_row(32'd0, 32'd1, 7'd1, 40'd256, 1'b0, EVT_NONE));
      plan.push_back(known_row(32'd0, 32'd2, 7'd1, 40'd512, 1'b0, EVT_NONE));
      plan.push_back(req_row(32'd119));             // span reaches the full window
      plan.push_back(req_row(32'd120));             // oldest second evicted
      plan.push_back(req_row(32'd5));               // late but still inside
      plan.push_back(req_row(32'd0));               // stale, no state change
      plan.push_back(csr_row('0));
      plan.push_back(req_row(32'd120));             // zero threshold raises
      plan.push_back(csr_row('1));
      plan.push_back(req_row(32'd121));             // top threshold recovers
      // large jump leaves one second in the window
      plan.push_back(known_row(32'd1000, 32'd1, 7'd1, 40'd256, 1'b0, EVT_NONE));
      plan.push_back(csr_row(16'd1));
      plan.push_back(known_row(32'd1000, 32'd2, 7'd1, 40'd512, 1'b1, EVT_RAISED));
      plan.push_back(req_row(32'd1127));            // evicts all, window restarts
      plan.push_back(req_row(32'd1008));            // back fill to a full span
      plan.push_back(req_row(32'd1128));            // evict one, walk to survivor
      plan.push_back(req_row(32'h7FFF_FFFF));
      plan.push_back(req_row(32'h7FFF_FFFF));
      plan.push_back(req_row(32'h8000_0001));       // span crosses bit 31
      plan.push_back(req_row(32'h7FFF_FF80));       // stale across bit 31
      plan.push_back(req_row(32'h8000_0078));       // evicts two seconds

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      foreach (plan[i]) begin
         if (plan[i].kind == ROW_CSR) begin
            req_valid <= 1'b0;
            write_threshold(plan[i].value[THRESH_W-1:0]);
         end else begin
            send_stamp(plan[i].value, plan[i].known, plan[i].want);
         end
      end

      // random phases: sender mostly busy, then receiver mostly busy, then no idling
      for (phase = 0; phase < RANDOM_PHASES; phase++) begin
         req_valid <= 1'b0;
         case (phase)
            0, 1: begin
               send_idle_pct = 9;
               stall_pct = 75;
            end
            2, 3: begin
               send_idle_pct = 75;
               stall_pct = 9;
            end
            default: begin
               send_idle_pct = 0;
               stall_pct = 0;
            end
         endcase
         case (phase)
            0: next_threshold = 16'd2;
            1: next_threshold = 16'd1;
            2: next_threshold = 16'd3;
            3: next_threshold = '1;
            4: next_threshold = '0;
            default: next_threshold = THRESH_W'($urandom_range(1, 4));
         endcase
         write_threshold(next_threshold);
         for (k = 0; k < WORDS_PER_PHASE; k++) begin
            // top of the stamp range only late, since the newest second never comes back down
            if (phase == RANDOM_PHASES - 1 && k == WORDS_PER_PHASE / 2)
               stamp = STAMP_MAX;
            else
               stamp = pick_stamp();
            send_stamp(stamp, 1'b0, '0);
         end
      end
      req_valid <= 1'b0;

      // drain, then let any stray word show up
      while (expected_reports.size() != 0)
         @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (error_count == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule
